### rtl/bgib_pkg.sv
// Shared constants for the battery gauge icon blinker: register indexes,
// reset values, icon modes and icon column bytes.
// No dependencies.
`default_nettype none

package bgib_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_MV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_MS = 2'd3;

	// Register reset values
	localparam logic [15:0] EMPTY_MV_RST = 16'd14000;
	localparam logic [15:0] FULL_MV_RST = 16'd16800;
	localparam logic [6:0] LOW_PCT_RST = 7'd10;
	localparam logic [15:0] BLINK_MS_RST = 16'd250;

	// Request codes carried on the input tuser
	localparam logic [1:0] REQ_STATUS = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_ENTER = 2'd2;

	// Result kinds
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_ICON = 1'b1;

	// Icon display modes
	typedef logic [1:0] icon_mode_t;
	localparam icon_mode_t ICON_FILL = 2'd0;
	localparam icon_mode_t ICON_OUTLINE = 2'd1;
	localparam icon_mode_t ICON_NONE = 2'd2;

	// Icon column bytes
	localparam logic [7:0] COL_EDGE = 8'hFF;
	localparam logic [7:0] COL_FRAME = 8'h81;
	localparam logic [7:0] COL_TICK = 8'h3C;
	localparam logic [4:0] COL_FIRST = 5'd31;
	localparam int unsigned ICON_COLS = 10;

	// Percentage constants
	localparam logic signed [7:0] PCT_NONE = -8'sd1;
	localparam logic signed [7:0] PCT_FULL = 8'sd100;
	localparam logic [1:0] STATUS_LOW_BIT = 2'd1;

	// Default number of tick slots in the icon
	localparam int unsigned TICK_SLOTS_DEF = 6;

endpackage

`default_nettype wire

### rtl/battery_gauge_icon_blinker.sv
// Battery gauge page sequencer: percentage via a bit-serial divider, blink
// control and icon column emission through one output register.
// Depends on bgib_pkg.
`default_nettype none

// Channel   Dir   Handshake                 Payload
// s_*       in    s_tvalid / s_tready       tuser req_type, tdata now/vbat/flags
// m_*       out   m_tvalid / m_tready       tuser kind, tlast last, tdata fields
// cfg_*     in    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A tick folds the span in ST_PREP, runs the restoring divider in ST_DIV
// (one quotient bit per cycle) unless the percentage is a clamp case,
// settles alarm and blink in ST_EVAL, then emits one result per cycle as
// m_tready allows (eleven at most). Status, enter and unused items are handled in ST_IDLE.
// The input is not taken while a tick is in progress; the last result may
// still wait in the output register while the next item is accepted.
// Reset clears the control, page and configuration state at once; no clearing pass.

module battery_gauge_icon_blinker #(
	parameter int unsigned TICK_SLOTS = bgib_pkg::TICK_SLOTS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// input items
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [63:0]                      s_tdata,  // now_ms[31:0], vbat_mv, status_flags
	input  wire  [1:0]                       s_tuser,  // req_type
	// result items
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [23:0]                      m_tdata,  // percent, column, column_bits, pad
	output logic                             m_tuser,  // kind
	output logic                             m_tlast,  // last
	// configuration writes
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [bgib_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [bgib_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bgib_pkg::*;

	localparam int unsigned FW = $clog2(TICK_SLOTS + 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_EVAL = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;

	// Configuration registers
	logic [15:0] empty_mv_q, full_mv_q, blink_ms_q;
	logic [6:0] low_pct_q;

	// Page and telemetry state
	logic telem_q, low_flag_q, shown_valid_q, phase_q;
	logic [15:0] batt_mv_q;
	logic signed [7:0] shown_pct_q;
	icon_mode_t shown_icon_q;
	logic [31:0] stamp_q, now_q;

	// Working registers
	logic signed [7:0] pct_q;
	logic [23:0] rem_q;
	logic [22:0] dsh_q;
	logic [5:0] quo_q;
	logic [2:0] bit_q;
	icon_mode_t want_q;
	logic [FW-1:0] filled_q;
	logic [3:0] emit_q;

	// Output register
	logic m_valid_q, m_kind_q, m_last_q;
	logic [23:0] m_data_q;

	logic s_acc, load_out;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_kind_q;
	assign m_tlast = m_last_q;

	// Span and offset, sign folded so that the span is positive
	logic signed [16:0] span_raw, off_raw, span_f, off_f;
	always_comb begin
		span_raw = $signed({1'b0, full_mv_q}) - $signed({1'b0, empty_mv_q});
		off_raw = $signed({1'b0, batt_mv_q}) - $signed({1'b0, empty_mv_q});
		if (span_raw < 0) begin
			span_f = -span_raw;
			off_f = -off_raw;
		end else begin
			span_f = span_raw;
			off_f = off_raw;
		end
	end

	// Rounded quotient numerator 200*off + span
	logic [23:0] numer;
	assign numer = 24'(off_f[15:0]) * 24'd200 + 24'(span_f[15:0]);

	// Divider step: one quotient bit per cycle
	logic div_ge;
	assign div_ge = rem_q >= {1'b0, dsh_q};

	// Alarm, blink and icon decision
	logic alarm, blink_due, phase_nx, text_chg, icon_chg;
	icon_mode_t want;
	logic [31:0] elapsed;
	always_comb begin
		alarm = low_flag_q || (!pct_q[7] && (pct_q[6:0] < low_pct_q));
		elapsed = now_q - stamp_q;
		blink_due = elapsed >= {16'd0, blink_ms_q};
		if (!alarm) begin
			phase_nx = 1'b1;
		end else if (blink_due) begin
			phase_nx = !phase_q;
		end else begin
			phase_nx = phase_q;
		end
		if (!alarm) begin
			want = ICON_FILL;
		end else if (phase_nx) begin
			want = ICON_OUTLINE;
		end else begin
			want = ICON_NONE;
		end
		text_chg = !shown_valid_q || (pct_q != shown_pct_q);
		icon_chg = want != shown_icon_q;
	end

	// Filled tick slots: round(pct * slots / 100) by threshold compares, zero unless a filled icon
	logic [FW-1:0] filled;
	logic [15:0] scaled;
	always_comb begin
		scaled = 16'(pct_q[6:0]) * 16'(TICK_SLOTS) + 16'd50;
		filled = '0;
		for (int k = 1; k <= int'(TICK_SLOTS); k++) begin
			if (scaled >= 16'(100 * k)) begin
				filled = FW'(k);
			end
		end
		if (want != ICON_FILL || pct_q[7]) begin
			filled = '0;
		end
	end

	// Next result from the emit counter
	logic [3:0] col_v;
	logic [7:0] col_bits;
	logic [23:0] nx_data;
	logic nx_kind, nx_last;
	always_comb begin
		col_v = emit_q - 4'd1;
		if (want_q == ICON_NONE) begin
			col_bits = 8'h00;
		end else if (col_v == 4'd0 || col_v == 4'd8) begin
			col_bits = COL_EDGE;
		end else if (col_v == 4'd9) begin
			col_bits = COL_TICK;
		end else if (col_v >= 4'd2 && ({1'b0, col_v} - 5'd2) < 5'(filled_q)) begin
			col_bits = COL_FRAME | COL_TICK;
		end else begin
			col_bits = COL_FRAME;
		end
		if (emit_q == 4'd0) begin
			nx_kind = KIND_TEXT;
			nx_last = 1'b0;
			nx_data = {16'd0, pct_q};
		end else begin
			nx_kind = KIND_ICON;
			nx_last = (col_v == 4'(ICON_COLS - 1));
			nx_data = {3'd0, col_bits, COL_FIRST - {1'b0, col_v}, 8'd0};
		end
	end

	assign load_out = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_mv_q <= EMPTY_MV_RST;
			full_mv_q <= FULL_MV_RST;
			low_pct_q <= LOW_PCT_RST;
			blink_ms_q <= BLINK_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EMPTY_MV: empty_mv_q <= cfg_data;
				REG_FULL_MV: full_mv_q <= cfg_data;
				REG_LOW_PCT: low_pct_q <= cfg_data[6:0];
				REG_BLINK_MS: blink_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and page state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			telem_q <= 1'b0;
			batt_mv_q <= '0;
			low_flag_q <= 1'b0;
			shown_valid_q <= 1'b0;
			shown_pct_q <= '0;
			shown_icon_q <= ICON_FILL;
			phase_q <= 1'b1;
			stamp_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (s_tuser)
							REQ_STATUS: begin
								batt_mv_q <= s_tdata[47:32];
								low_flag_q <= s_tdata[48 + STATUS_LOW_BIT];
								telem_q <= 1'b1;
							end
							REQ_TICK: state_q <= ST_PREP;
							REQ_ENTER: begin
								shown_valid_q <= 1'b0;
								shown_pct_q <= '0;
								shown_icon_q <= ICON_FILL;
								phase_q <= 1'b1;
								stamp_q <= s_tdata[31:0];
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					if (!telem_q || span_f == 0 || off_f <= 0 || off_f >= span_f) begin
						state_q <= ST_EVAL;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_q == 3'd0) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					phase_q <= phase_nx;
					if (alarm && blink_due) begin
						stamp_q <= now_q;
					end
					if (text_chg || icon_chg) begin
						shown_pct_q <= pct_q;
						shown_valid_q <= 1'b1;
						shown_icon_q <= want;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (load_out && emit_q == 4'(ICON_COLS)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers: percentage, divider and emit counter
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				now_q <= s_tdata[31:0];
			end
			ST_PREP: begin
				if (!telem_q || span_f == 0) begin
					pct_q <= PCT_NONE;
				end else if (off_f <= 0) begin
					pct_q <= '0;
				end else if (off_f >= span_f) begin
					pct_q <= PCT_FULL;
				end
				rem_q <= numer;
				dsh_q <= {span_f[15:0], 7'd0};
				quo_q <= '0;
				bit_q <= 3'd6;
			end
			ST_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - {1'b0, dsh_q};
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[4:0], div_ge};
				bit_q <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					pct_q <= {1'b0, quo_q, div_ge};
				end
			end
			ST_EVAL: begin
				want_q <= want;
				filled_q <= filled;
				emit_q <= text_chg ? 4'd0 : 4'd1;
			end
			ST_EMIT: begin
				if (load_out) begin
					emit_q <= emit_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	// Output register: hold until taken, load the next result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= nx_data;
			m_kind_q <= nx_kind;
			m_last_q <= nx_last;
		end
	end

	// Only the final icon column closes a burst
	a_last_icon: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_ICON && m_tdata[12:8] == 5'd22))
		else $error("last flag on a result other than the final icon column");

	// Text results carry a percentage in -1..100
	a_text_pct: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_TEXT) |->
		($signed(m_tdata[7:0]) >= -8'sd1 && $signed(m_tdata[7:0]) <= PCT_FULL))
		else $error("text result percentage out of range");

	// Icon columns stay within the icon area
	a_icon_col: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_ICON) |-> (m_tdata[12:8] >= 5'd22))
		else $error("icon column outside the icon area");

	// No new item is taken while a burst is still being loaded
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !load_out) |=> !s_tready)
		else $error("input accepted during result emission");

endmodule

`default_nettype wire
